[sv/ffra_pkg.sv]
// Shared types, codes and constants for the first-fit run allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

  // Default sizes handed to the top-level parameters
  localparam int LOT_SLOTS_DEF = 16;
  localparam int KEY_COUNT_DEF = 16;

  // Fixed field widths of the request and response channels
  localparam int REQ_W     = 2;
  localparam int KEY_W     = 4;
  localparam int CLS_W     = 2;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 4;
  localparam int FREE_W    = 5;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Reset run lengths of the three size classes
  localparam logic [LEN_W-1:0] SMALL_LEN_RST  = LEN_W'(1);
  localparam logic [LEN_W-1:0] MEDIUM_LEN_RST = LEN_W'(3);
  localparam logic [LEN_W-1:0] LARGE_LEN_RST  = LEN_W'(5);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_NOP     = 2'd3
  } req_e_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_SMALL  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LARGE  = 2'd2,
    CLS_NONE   = 2'd3
  } cls_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_RUN    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_HELD      = 2'd3
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMALL_LEN  = 2'd0,
    CFG_MEDIUM_LEN = 2'd1,
    CFG_LARGE_LEN  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FILL,
    S_CLEAR,
    S_FINISH
  } seq_state_t;

  // Command from the sequencer to the slot bitmap
  typedef struct packed {
    logic write;
    logic used;
  } map_cmd_t;

endpackage

`default_nettype wire

[sv/ffra_slot_map.sv]
// Slot occupancy bitmap: one flag per slot, one slot read and written a cycle.
// Depends on ffra_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module ffra_slot_map #(
  parameter int LOT_SLOTS = ffra_pkg::LOT_SLOTS_DEF,
  parameter int SLOT_W    = (LOT_SLOTS > 1) ? $clog2(LOT_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffra_pkg::map_cmd_t   cmd,
  input  wire logic [SLOT_W-1:0]    addr,
  output logic                      used_bit
);
  import ffra_pkg::*;

  logic [LOT_SLOTS-1:0] slot_used;

  // Read the addressed slot
  assign used_bit = slot_used[addr];

  // Clear on reset, update one slot per command
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (cmd.write) begin
      slot_used[addr] <= cmd.used;
    end
  end

endmodule

`default_nettype wire

[sv/ffra_seq.sv]
// Request sequencer: config regs, key table, free count, slot scan/fill/clear
// loops and response register. Depends on ffra_pkg; drives ffra_slot_map.
`timescale 1ns / 1ps
`default_nettype none

module ffra_seq #(
  parameter int LOT_SLOTS = ffra_pkg::LOT_SLOTS_DEF,
  parameter int KEY_COUNT = ffra_pkg::KEY_COUNT_DEF,
  parameter int SLOT_W    = (LOT_SLOTS > 1) ? $clog2(LOT_SLOTS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffra_pkg::LEN_W-1:0]      cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic [ffra_pkg::REQ_W-1:0]      req_type,
  input  wire logic [ffra_pkg::KEY_W-1:0]      vehicle_key,
  input  wire logic [ffra_pkg::CLS_W-1:0]      vehicle_class,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic [ffra_pkg::STAT_W-1:0]          status,
  output logic [ffra_pkg::POS_W-1:0]           position,
  output logic [ffra_pkg::FREE_W-1:0]          free_slots,
  output ffra_pkg::map_cmd_t                   map_cmd,
  output logic [SLOT_W-1:0]                    map_addr,
  input  wire logic                            map_used
);
  import ffra_pkg::*;

  localparam int KEY_DEPTH = (KEY_COUNT < (1 << KEY_W)) ? KEY_COUNT : (1 << KEY_W);
  localparam int KEY_IW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_SLOTS = 1 << KEY_IW;
  localparam int CNT_W     = $clog2(LOT_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LOT_SLOTS - 1);
  localparam logic [CNT_W:0]    LOT_FULL  = (CNT_W + 1)'(LOT_SLOTS);

  // Configuration registers
  logic [LEN_W-1:0] small_len, medium_len, large_len;

  // Key table
  logic [KEY_SLOTS-1:0] key_valid;
  logic [SLOT_W-1:0]    key_start  [KEY_SLOTS];
  logic [LEN_W-1:0]     key_length [KEY_SLOTS];

  // Sequencer state
  seq_state_t       state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic [SLOT_W-1:0] cand, cand_next;
  logic [LEN_W-1:0]  run, run_next;
  logic [LEN_W-1:0]  remain, remain_next;
  logic [LEN_W-1:0]  len_q, len_q_next;
  logic [REQ_W-1:0]  req_q;
  logic [KEY_W-1:0]  key_q;
  status_e_t         res_status, res_status_next;
  logic [SLOT_W-1:0] res_pos, res_pos_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic              fill_done, clear_done;

  // Response register
  logic                 rsp_load;
  logic [STAT_W-1:0]    status_q;
  logic [POS_W-1:0]     position_q;
  logic [FREE_W-1:0]    free_q;

  logic [KEY_IW-1:0] kidx;
  logic              key_in_range;
  logic [LEN_W-1:0]  class_len;
  logic [LEN_W:0]    run_inc;
  logic [CNT_W:0]    free_sum;

  assign kidx         = key_q[KEY_IW-1:0];
  assign key_in_range = 32'(key_q) < KEY_COUNT;
  assign run_inc      = {1'b0, run} + (LEN_W + 1)'(1);
  assign free_sum     = {1'b0, free_count} + (CNT_W + 1)'(len_q);

  assign req_ready  = (state == S_IDLE);
  assign status     = status_q;
  assign position   = position_q;
  assign free_slots = free_q;

  // Map the request class to its run length
  always_comb begin
    case (vehicle_class)
      CLS_SMALL:  class_len = small_len;
      CLS_MEDIUM: class_len = medium_len;
      CLS_LARGE:  class_len = large_len;
      default:    class_len = '0;
    endcase
  end

  // Hold configuration; the user must write only while idle; no check enforces it
  always_ff @(posedge clk) begin
    if (rst) begin
      small_len  <= SMALL_LEN_RST;
      medium_len <= MEDIUM_LEN_RST;
      large_len  <= LARGE_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SMALL_LEN:  small_len  <= cfg_data;
        CFG_MEDIUM_LEN: medium_len <= cfg_data;
        CFG_LARGE_LEN:  large_len  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Next state, slot commands and result selection
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cand_next       = cand;
    run_next        = run;
    remain_next     = remain;
    len_q_next      = len_q;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    free_count_next = free_count;
    map_cmd         = '0;
    map_addr        = cnt;
    fill_done       = 1'b0;
    clear_done      = 1'b0;
    rsp_load        = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          len_q_next = class_len;
          state_next = S_DECIDE;
        end
      end

      // Settle the cheap cases, or launch a scan or a release sweep
      S_DECIDE: begin
        res_status_next = ST_OK;
        res_pos_next    = '0;
        state_next      = S_FINISH;
        if (req_q == REQ_NOP) begin
          res_status_next = ST_OK;
        end else if (!key_in_range) begin
          res_status_next = ST_NOT_FOUND;
        end else if (req_q == REQ_ALLOC) begin
          if (key_valid[kidx]) begin
            res_status_next = ST_HELD;
          end else if (len_q == '0 || 32'(len_q) > LOT_SLOTS ||
                       32'(free_count) < 32'(len_q)) begin
            res_status_next = ST_NO_RUN;
          end else begin
            cnt_next   = '0;
            run_next   = '0;
            state_next = S_SCAN;
          end
        end else if (!key_valid[kidx]) begin
          res_status_next = ST_NOT_FOUND;
        end else if (req_q == REQ_RELEASE) begin
          cnt_next     = key_start[kidx];
          res_pos_next = key_start[kidx];
          len_q_next   = key_length[kidx];
          remain_next  = key_length[kidx];
          state_next   = S_CLEAR;
        end else begin
          res_pos_next = key_start[kidx];
        end
      end

      // Walk the slots one per cycle, counting the current free run
      S_SCAN: begin
        if (!map_used) begin
          if (run == '0) begin
            cand_next = cnt;
          end
          if (run_inc == {1'b0, len_q}) begin
            res_pos_next = (run == '0) ? cnt : cand;
            cnt_next     = (run == '0) ? cnt : cand;
            remain_next  = len_q;
            state_next   = S_FILL;
          end else begin
            run_next = run_inc[LEN_W-1:0];
          end
        end else begin
          run_next = '0;
        end
        if (state_next == S_SCAN) begin
          if (cnt == LAST_SLOT) begin
            res_status_next = ST_NO_RUN;
            state_next      = S_FINISH;
          end else begin
            cnt_next = cnt + SLOT_W'(1);
          end
        end
      end

      // Mark the found run used
      S_FILL: begin
        map_cmd.write = 1'b1;
        map_cmd.used  = 1'b1;
        cnt_next      = cnt + SLOT_W'(1);
        remain_next   = remain - LEN_W'(1);
        if (remain == LEN_W'(1)) begin
          fill_done       = 1'b1;
          free_count_next = free_count - CNT_W'(len_q);
          state_next      = S_FINISH;
        end
      end

      // Free the released run
      S_CLEAR: begin
        map_cmd.write = 1'b1;
        map_cmd.used  = 1'b0;
        cnt_next      = cnt + SLOT_W'(1);
        remain_next   = remain - LEN_W'(1);
        if (remain == LEN_W'(1)) begin
          clear_done      = 1'b1;
          free_count_next = (free_sum > LOT_FULL) ? CNT_W'(LOT_SLOTS) : free_sum[CNT_W-1:0];
          state_next      = S_FINISH;
        end
      end

      // Load the response once the register is free
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= CNT_W'(LOT_SLOTS);
      key_valid  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      if (fill_done) begin
        key_valid[kidx] <= 1'b1;
      end else if (clear_done) begin
        key_valid[kidx] <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    cand       <= cand_next;
    run        <= run_next;
    remain     <= remain_next;
    len_q      <= len_q_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (req_valid && req_ready) begin
      req_q <= req_type;
      key_q <= vehicle_key;
    end
    if (fill_done) begin
      key_start[kidx]  <= res_pos;
      key_length[kidx] <= len_q;
    end
    if (rsp_load) begin
      status_q   <= res_status;
      position_q <= POS_W'(res_pos);
      free_q     <= FREE_W'(free_count);
    end
  end

endmodule

`default_nettype wire

[sv/first_fit_run_allocator_unit.sv]
// Path: query, no-op, bad key, held key or rejected allocate pass through the
// decide and finish states; release adds the clear loop over its run; allocate
// adds the one-slot-per-cycle scan and the fill loop; finish waits for a free
// response register. Throughput: one request at a time; the next is taken in
// the cycle after the response is loaded. Reset (rst, sync): all slots free,
// no key held, free count LOT_SLOTS, lengths 1, 3, 5, no response.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_run_allocator_unit #(
  parameter int LOT_SLOTS = ffra_pkg::LOT_SLOTS_DEF,
  parameter int KEY_COUNT = ffra_pkg::KEY_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffra_pkg::LEN_W-1:0]      cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic [ffra_pkg::REQ_W-1:0]      req_type,
  input  wire logic [ffra_pkg::KEY_W-1:0]      vehicle_key,
  input  wire logic [ffra_pkg::CLS_W-1:0]      vehicle_class,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic [ffra_pkg::STAT_W-1:0]          status,
  output logic [ffra_pkg::POS_W-1:0]           position,
  output logic [ffra_pkg::FREE_W-1:0]          free_slots
);
  import ffra_pkg::*;

  localparam int SLOT_W = (LOT_SLOTS > 1) ? $clog2(LOT_SLOTS) : 1;

  map_cmd_t          map_cmd;
  logic [SLOT_W-1:0] map_addr;
  logic              map_used;

  // Sequencer with key table and response register
  ffra_seq #(
    .LOT_SLOTS (LOT_SLOTS),
    .KEY_COUNT (KEY_COUNT),
    .SLOT_W    (SLOT_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .vehicle_key   (vehicle_key),
    .vehicle_class (vehicle_class),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .position      (position),
    .free_slots    (free_slots),
    .map_cmd       (map_cmd),
    .map_addr      (map_addr),
    .map_used      (map_used)
  );

  // Slot occupancy bitmap
  ffra_slot_map #(
    .LOT_SLOTS (LOT_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .cmd      (map_cmd),
    .addr     (map_addr),
    .used_bit (map_used)
  );

endmodule

`default_nettype wire

[sv/ffra_checker.sv]
// Port-level checks for first_fit_run_allocator_unit, bound to the top level.
// Depends on ffra_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module ffra_checker #(
  parameter int LOT_SLOTS = ffra_pkg::LOT_SLOTS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [ffra_pkg::STAT_W-1:0]     status,
  input wire logic [ffra_pkg::POS_W-1:0]      position,
  input wire logic [ffra_pkg::FREE_W-1:0]     free_slots
);
  import ffra_pkg::*;

  // Drop any pending response on reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position)
      && $stable(free_slots))
    else $error("stalled response changed");

  // Take one request at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Report position zero on any failure
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> position == '0)
    else $error("nonzero position on failed request");

  // Never report more free slots than the lot has
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (LOT_SLOTS > 31) || (32'(free_slots) <= LOT_SLOTS))
    else $error("free count above lot size");

endmodule

bind first_fit_run_allocator_unit ffra_checker #(
  .LOT_SLOTS (LOT_SLOTS)
) u_ffra_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .status     (status),
  .position   (position),
  .free_slots (free_slots)
);

`default_nettype wire

[sim/first_fit_run_allocator_unit_tb.sv]
// Self-checking testbench for first_fit_run_allocator_unit: directed and random
// allocate, release and query requests, checked against an in-bench predictor.
// Depends on ffra_pkg and the RTL of the allocator unit.
`timescale 1ns / 1ps

module first_fit_run_allocator_unit_tb;
  import ffra_pkg::*;

  localparam int SLOTS         = LOT_SLOTS_DEF;
  localparam int KEYS          = KEY_COUNT_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 40;

  // Predictor of the allocator plus the queue of answers still owed
  class run_alloc_scoreboard;
    typedef struct {
      status_e_t         st;
      logic [POS_W-1:0]  pos;
      logic [FREE_W-1:0] free;
    } answer_t;

    bit                 lot_busy[SLOTS];
    bit                 key_owns[KEYS];
    logic [POS_W-1:0]   owner_start[KEYS];
    logic [LEN_W-1:0]   owner_len[KEYS];
    int                 slots_free;
    logic [LEN_W-1:0]   len_of_class[3];
    answer_t            answers_due[$];
    int                 errors;

    function new();
      foreach (lot_busy[i]) lot_busy[i] = 1'b0;
      foreach (key_owns[i]) key_owns[i] = 1'b0;
      slots_free      = SLOTS;
      len_of_class[0] = SMALL_LEN_RST;
      len_of_class[1] = MEDIUM_LEN_RST;
      len_of_class[2] = LARGE_LEN_RST;
      errors          = 0;
    endfunction

    function void set_length(cfg_idx_e_t idx, logic [LEN_W-1:0] v);
      case (idx)
        CFG_SMALL_LEN:  len_of_class[0] = v;
        CFG_MEDIUM_LEN: len_of_class[1] = v;
        CFG_LARGE_LEN:  len_of_class[2] = v;
        default: ;
      endcase
    endfunction

    function void note_request(req_e_t rt, logic [KEY_W-1:0] key, cls_e_t cls);
      answer_t a;
      int      len;
      int      start;
      int      i;
      int      j;
      bit      fits;
      a.st  = ST_OK;
      a.pos = '0;
      if (rt != REQ_NOP && int'(key) >= KEYS) begin
        a.st = ST_NOT_FOUND;
      end else begin
        case (rt)
          REQ_ALLOC: begin
            if (key_owns[key]) begin
              a.st = ST_HELD;
            end else begin
              case (cls)
                CLS_SMALL:  len = len_of_class[0];
                CLS_MEDIUM: len = len_of_class[1];
                CLS_LARGE:  len = len_of_class[2];
                default:    len = 0;
              endcase
              start = -1;
              // lowest window of len free slots, last fit included
              if (len != 0 && len <= SLOTS && slots_free >= len) begin
                for (i = 0; i + len <= SLOTS && start < 0; i++) begin
                  fits = 1'b1;
                  for (j = 0; j < len; j++)
                    if (lot_busy[i + j]) fits = 1'b0;
                  if (fits) start = i;
                end
              end
              if (start < 0) begin
                a.st = ST_NO_RUN;
              end else begin
                for (j = 0; j < len; j++) lot_busy[start + j] = 1'b1;
                key_owns[key]    = 1'b1;
                owner_start[key] = POS_W'(start);
                owner_len[key]   = LEN_W'(len);
                slots_free       = slots_free - len;
                a.pos            = POS_W'(start);
              end
            end
          end
          REQ_RELEASE: begin
            if (!key_owns[key]) begin
              a.st = ST_NOT_FOUND;
            end else begin
              for (j = 0; j < owner_len[key]; j++)
                if (owner_start[key] + j < SLOTS) lot_busy[owner_start[key] + j] = 1'b0;
              slots_free = slots_free + owner_len[key];
              if (slots_free > SLOTS) slots_free = SLOTS;
              key_owns[key] = 1'b0;
              a.pos         = owner_start[key];
            end
          end
          REQ_QUERY: begin
            if (!key_owns[key]) a.st = ST_NOT_FOUND;
            else a.pos = owner_start[key];
          end
          default: ;
        endcase
      end
      a.free = FREE_W'(slots_free);
      answers_due.push_back(a);
    endfunction

    function void check_response(logic [STAT_W-1:0] st, logic [POS_W-1:0] pos,
                                 logic [FREE_W-1:0] free);
      answer_t a;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected response: status %0d position %0d free %0d",
                 $time, st, pos, free);
        errors++;
        return;
      end
      a = answers_due.pop_front();
      if (st !== a.st) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, a.st, st);
        errors++;
      end
      if (pos !== a.pos) begin
        $display("%0t: position mismatch: expected %0d, actual %0d", $time, a.pos, pos);
        errors++;
      end
      if (free !== a.free) begin
        $display("%0t: free_slots mismatch: expected %0d, actual %0d", $time, a.free, free);
        errors++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  cfg_idx_e_t          cfg_index;
  logic [LEN_W-1:0]    cfg_data;
  logic                req_valid;
  logic                req_ready;
  req_e_t              req_type;
  logic [KEY_W-1:0]    vehicle_key;
  cls_e_t              vehicle_class;
  logic                rsp_valid;
  logic                rsp_ready;
  logic [STAT_W-1:0]   status;
  logic [POS_W-1:0]    position;
  logic [FREE_W-1:0]   free_slots;

  run_alloc_scoreboard sb;
  bit                  no_idle;
  bit                  sink_hold_req;

  first_fit_run_allocator_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .vehicle_key   (vehicle_key),
    .vehicle_class (vehicle_class),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .position      (position),
    .free_slots    (free_slots)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offer one request and hold it until accepted; valid stays high on a zero gap
  task automatic send_request(req_e_t rt, logic [KEY_W-1:0] key, cls_e_t cls);
    int gap;
    req_valid     = 1'b1;
    req_type      = rt;
    vehicle_key   = key;
    vehicle_class = cls;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every answer owed has come back
  task automatic drain_requests();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e_t idx, logic [LEN_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_lengths(logic [LEN_W-1:0] s, logic [LEN_W-1:0] m, logic [LEN_W-1:0] l);
    write_reg(CFG_SMALL_LEN, s);
    write_reg(CFG_MEDIUM_LEN, m);
    write_reg(CFG_LARGE_LEN, l);
    write_reg(CFG_UNUSED, LEN_W'($urandom));
  endtask

  task automatic random_request(int alloc_pct);
    int     r;
    req_e_t rt;
    cls_e_t cls;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) rt = REQ_ALLOC;
    else if (r < alloc_pct + 25) rt = REQ_RELEASE;
    else if (r < 95) rt = REQ_QUERY;
    else rt = REQ_NOP;
    if ($urandom_range(0, 19) == 0) cls = CLS_NONE;
    else cls = cls_e_t'($urandom_range(0, 2));
    send_request(rt, KEY_W'($urandom_range(0, 15)), cls);
  endtask

  // Note accepted requests and register writes, check accepted responses
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_length(cfg_index, cfg_data);
      if (req_valid && req_ready) sb.note_request(req_type, vehicle_key, vehicle_class);
      if (rsp_valid && rsp_ready) sb.check_response(status, position, free_slots);
    end
  end

  // Response side: random back-pressure, plus one long hold on demand
  initial begin : response_sink
    int stall;
    bit hold_done;
    stall     = 0;
    hold_done = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req && !hold_done) begin
        hold_done = 1'b1;
        rsp_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall > 0) begin
        rsp_ready = 1'b0;
        stall--;
      end else begin
        rsp_ready = 1'b1;
        stall     = pick_gap();
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("first_fit_run_allocator_unit test failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int n;
    int alloc_pct;
    sb            = new();
    no_idle       = 1'b0;
    sink_hold_req = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SMALL_LEN;
    cfg_data      = '0;
    req_valid     = 1'b0;
    req_type      = REQ_NOP;
    vehicle_key   = '0;
    vehicle_class = CLS_SMALL;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Reset lengths: misses, first fit, hole reuse, held key, bad class, no-op
    send_request(REQ_QUERY,   4'd0,  CLS_SMALL);
    send_request(REQ_RELEASE, 4'd15, CLS_LARGE);
    send_request(REQ_ALLOC,   4'd0,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd0,  CLS_MEDIUM);
    send_request(REQ_ALLOC,   4'd1,  CLS_MEDIUM);
    send_request(REQ_ALLOC,   4'd2,  CLS_LARGE);
    send_request(REQ_ALLOC,   4'd3,  CLS_NONE);
    send_request(REQ_QUERY,   4'd2,  CLS_NONE);
    send_request(REQ_RELEASE, 4'd1,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd4,  CLS_SMALL);
    send_request(REQ_NOP,     4'd15, CLS_NONE);
    send_request(REQ_RELEASE, 4'd0,  CLS_SMALL);
    send_request(REQ_RELEASE, 4'd0,  CLS_SMALL);
    send_request(REQ_RELEASE, 4'd2,  CLS_SMALL);
    send_request(REQ_RELEASE, 4'd4,  CLS_SMALL);
    drain_requests();

    // Whole lot in one run, zero length, length beyond the lot
    set_lengths(5'd16, 5'd0, 5'd31);
    send_request(REQ_ALLOC,   4'd5,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd6,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd6,  CLS_MEDIUM);
    send_request(REQ_RELEASE, 4'd5,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd7,  CLS_LARGE);
    drain_requests();

    // Run ending on the last slot, then free count below the length
    set_lengths(5'd15, 5'd1, 5'd16);
    send_request(REQ_ALLOC,   4'd8,  CLS_MEDIUM);
    send_request(REQ_ALLOC,   4'd9,  CLS_SMALL);
    send_request(REQ_QUERY,   4'd9,  CLS_SMALL);
    send_request(REQ_RELEASE, 4'd8,  CLS_SMALL);
    send_request(REQ_ALLOC,   4'd10, CLS_LARGE);
    drain_requests();

    // Random phases, each under its own length setting
    for (p = 0; p < 8; p++) begin
      alloc_pct = 50;
      no_idle   = 1'b0;
      case (p)
        0: set_lengths(5'd1, 5'd3, 5'd5);
        1: set_lengths(5'd2, 5'd4, 5'd6);
        2: begin
          set_lengths(5'd1, 5'd1, 5'd1);
          alloc_pct = 65;
        end
        3: set_lengths(5'd16, 5'd8, 5'd4);
        4: set_lengths(5'd0, 5'd17, 5'd31);
        5: begin
          set_lengths(LEN_W'($urandom_range(1, 16)), LEN_W'($urandom_range(1, 16)),
                      LEN_W'($urandom_range(1, 16)));
          no_idle = 1'b1;
        end
        6: begin
          set_lengths(LEN_W'($urandom_range(1, 16)), LEN_W'($urandom_range(1, 16)),
                      LEN_W'($urandom_range(1, 16)));
          alloc_pct = 45;
        end
        default: set_lengths(5'd1, 5'd2, 5'd3);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold the response side off while requests keep coming
        if (p == 1 && n == 40) sink_hold_req = 1'b1;
        random_request(alloc_pct);
      end
      drain_requests();
    end
    no_idle = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("first_fit_run_allocator_unit test passed");
    end else begin
      $display("first_fit_run_allocator_unit test failed");
    end
    $finish;
  end

endmodule
